@@ src/brb_pkg.sv @@
// Shared types and constants for the byte ring buffer unit.
// Depends on nothing; every other file of the unit but brb_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    // Operation codes carried in the command.
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_CONSUME = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;

    // Status codes reported with each result.
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_OVERRUN  = 2'd1;
    localparam logic [1:0] ST_UNDERRUN = 2'd2;

    // Jobs carry a start address wide enough for the largest supported depth.
    localparam int JOB_ADDR_W = 16;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] write_byte;
        logic [5:0] consume_count;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       byte_valid;
        logic       last_result;
        logic [1:0] status;
        logic [5:0] fill_level;
        logic [5:0] free_space;
    } res_t;

    // One unit of work handed from the front part to the back part.
    typedef struct packed {
        logic                  is_burst;
        logic [1:0]            status;
        logic [JOB_ADDR_W-1:0] start_addr;
        logic [5:0]            byte_count;
        logic [5:0]            fill_level;
        logic [5:0]            free_space;
    } job_t;

endpackage

`default_nettype wire

@@ src/brb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/brb_job_queue.sv @@
// Four-entry job queue between the front and back parts of the unit.
// Depends on brb_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module brb_job_queue
    import brb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      not_full,
    input  wire logic pop,
    output job_t      head_job,
    output logic      not_empty
);

    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    job_t       slot_reg [4];

    assign not_full  = (count_reg != 3'd4);
    assign not_empty = (count_reg != 3'd0);
    assign head_job  = slot_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = tail_reg + 2'd1;
        end
        if (pop)
        begin
            head_next = head_reg + 2'd1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ src/brb_front.sv @@
// Front part: accepts commands, keeps the pointers and fill level, writes
// bytes into the store and queues one job per command. Depends on brb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brb_front
    import brb_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int SW = ((AW > 6) ? AW : 6) + 1,
    localparam int FW = (AW > 6) ? AW : 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire cmd_t          command,
    output logic               busy,
    input  wire logic          queue_ready,
    output logic               job_push,
    output job_t               job,
    input  wire logic          release_byte,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_data
);

    logic [AW-1:0] rp_reg, rp_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] level_reg, level_next;
    logic [SW-1:0] pending_reg, pending_next;
    logic          drain_reg, drain_next;

    logic          accept;
    logic          full;
    logic          hazard;
    logic [AW-1:0] wp_inc;
    logic [SW-1:0] count_ext;
    logic [SW-1:0] level_ext;
    logic [SW-1:0] rp_sum;
    logic [SW-1:0] rp_wrap;
    logic [SW-1:0] level_left;
    logic [SW-1:0] pending_add;
    logic          burst;
    logic [1:0]    status;
    logic [AW-1:0] free_w;
    logic [FW-1:0] fill_big;
    logic [FW-1:0] free_big;

    // Bytes handed to the back part but not yet read out sit just behind the
    // read pointer; a write must not land there until they are read.
    assign hazard = ((pending_reg + level_ext) >= SW'(DEPTH));
    assign busy   = !queue_ready || hazard || (drain_reg && (pending_reg != '0));
    assign accept = start && !busy;

    assign full      = (level_reg == AW'(DEPTH - 1));
    assign wp_inc    = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign count_ext = SW'(command.consume_count);
    assign level_ext = SW'(level_reg);
    assign rp_sum    = SW'(rp_reg) + count_ext;
    assign rp_wrap   = (rp_sum >= SW'(DEPTH)) ? rp_sum - SW'(DEPTH) : rp_sum;
    assign level_left = level_ext - count_ext;

    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        level_next = level_reg;
        drain_next = drain_reg && (pending_reg != '0);
        wr_en      = 1'b0;
        burst      = 1'b0;
        status     = ST_NONE;
        unique case (command.operation)
            OP_WRITE:
            begin
                if (full)
                begin
                    status = ST_OVERRUN;
                end
                else
                begin
                    wr_en      = accept;
                    wp_next    = wp_inc;
                    level_next = level_reg + 1'b1;
                end
            end
            OP_CONSUME:
            begin
                if (level_ext < count_ext)
                begin
                    status = ST_UNDERRUN;
                end
                else if (count_ext != '0)
                begin
                    burst      = 1'b1;
                    rp_next    = rp_wrap[AW-1:0];
                    level_next = level_left[AW-1:0];
                end
            end
            OP_FLUSH:
            begin
                rp_next    = '0;
                wp_next    = '0;
                level_next = '0;
                drain_next = 1'b1;
            end
            default:
            begin
                status = ST_NONE;
            end
        endcase
    end

    assign pending_add  = (accept && burst) ? count_ext : '0;
    assign pending_next = pending_reg + pending_add - SW'(release_byte);

    assign free_w   = AW'(DEPTH - 1) - level_next;
    assign fill_big = FW'(level_next);
    assign free_big = FW'(free_w);

    assign job_push        = accept;
    assign job.is_burst    = burst;
    assign job.status      = status;
    assign job.start_addr  = JOB_ADDR_W'(rp_reg);
    assign job.byte_count  = command.consume_count;
    assign job.fill_level  = fill_big[5:0];
    assign job.free_space  = free_big[5:0];

    assign wr_addr = wp_reg;
    assign wr_data = command.write_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg      <= '0;
            wp_reg      <= '0;
            level_reg   <= '0;
            pending_reg <= '0;
            drain_reg   <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (accept)
            begin
                rp_reg    <= rp_next;
                wp_reg    <= wp_next;
                level_reg <= level_next;
                drain_reg <= drain_next;
            end
            else
            begin
                drain_reg <= drain_reg && (pending_reg != '0);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/brb_back.sv @@
// Back part: takes jobs from the queue, reads consumed bytes from the store
// one per cycle and drives the result register. Depends on brb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brb_back
    import brb_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire job_t          job,
    output logic               job_pop,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  wire logic [7:0]    rd_data,
    output logic               release_byte,
    output res_t               result,
    output logic               result_strobe
);

    logic          active_reg, active_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [5:0]    left_reg, left_next;
    logic [5:0]    fill_reg, fill_next;
    logic [5:0]    free_reg, free_next;

    logic          ovalid_reg, ovalid_next;
    logic          obyte_reg, obyte_next;
    logic          olast_reg, olast_next;
    logic [1:0]    ostatus_reg, ostatus_next;
    logic [5:0]    ofill_reg, ofill_next;
    logic [5:0]    ofree_reg, ofree_next;

    assign job_pop      = !active_reg && job_valid;
    assign rd_en        = active_reg;
    assign rd_addr      = addr_reg;
    assign release_byte = active_reg;

    always_comb
    begin
        active_next  = active_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        fill_next    = fill_reg;
        free_next    = free_reg;
        ovalid_next  = 1'b0;
        obyte_next   = 1'b0;
        olast_next   = 1'b1;
        ostatus_next = ST_NONE;
        ofill_next   = ofill_reg;
        ofree_next   = ofree_reg;
        if (active_reg)
        begin
            ovalid_next = 1'b1;
            obyte_next  = 1'b1;
            olast_next  = (left_reg == 6'd1);
            ofill_next  = fill_reg;
            ofree_next  = free_reg;
            addr_next   = (addr_reg == AW'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
            left_next   = left_reg - 6'd1;
            active_next = (left_reg != 6'd1);
        end
        else if (job_pop)
        begin
            if (job.is_burst)
            begin
                active_next = 1'b1;
                addr_next   = job.start_addr[AW-1:0];
                left_next   = job.byte_count;
                fill_next   = job.fill_level;
                free_next   = job.free_space;
            end
            else
            begin
                ovalid_next  = 1'b1;
                ostatus_next = job.status;
                ofill_next   = job.fill_level;
                ofree_next   = job.free_space;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        left_reg    <= left_next;
        fill_reg    <= fill_next;
        free_reg    <= free_next;
        obyte_reg   <= obyte_next;
        olast_reg   <= olast_next;
        ostatus_reg <= ostatus_next;
        ofill_reg   <= ofill_next;
        ofree_reg   <= ofree_next;
    end

    // Store read data is registered from the address at the same edge as the
    // result register, so the two are aligned.
    assign result_strobe      = ovalid_reg;
    assign result.read_byte   = obyte_reg ? rd_data : 8'd0;
    assign result.byte_valid  = obyte_reg;
    assign result.last_result = olast_reg;
    assign result.status      = ostatus_reg;
    assign result.fill_level  = ofill_reg;
    assign result.free_space  = ofree_reg;

endmodule

`default_nettype wire

@@ src/byte_ring_buffer_unit.sv @@
// Top level of the byte ring buffer unit.
// Depends on brb_pkg, brb_ram, brb_job_queue, brb_front and brb_back.
`timescale 1ns / 1ps
`default_nettype none

// The unit is a byte FIFO of DEPTH slots that always keeps one slot empty,
// so it holds at most DEPTH-1 bytes. A transaction is accepted at a rising
// edge where start is high and busy is low. A write stores one byte (or
// reports overrun when full) and produces one result; a consume of N bytes
// produces N results carrying the bytes oldest first, with last_result on the
// final one, or a single underrun result when fewer than N bytes are stored;
// a consume of zero bytes and a flush each produce one result. Every result
// reports fill level and free space as they stand after its transaction, both
// truncated to six bits. Results appear for exactly one cycle with
// result_strobe high and cannot be held off, so the receiver must take them
// as they come. The front part takes one transaction per cycle while its job
// queue (four entries) has room; the back part produces one result per cycle
// for each consumed byte and takes its next job only once a consume has read
// its last byte. busy also rises while a write could land on a slot whose
// byte has been consumed but not yet read out of the store, and after a
// flush until such bytes are read out.
module byte_ring_buffer_unit
    import brb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire cmd_t command,
    output logic      busy,
    output res_t      result,
    output logic      result_strobe
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          queue_ready;
    logic          queue_has_job;
    logic          job_push;
    logic          job_pop;
    job_t          push_job;
    job_t          head_job;
    logic          release_byte;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    brb_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .busy         (busy),
        .queue_ready  (queue_ready),
        .job_push     (job_push),
        .job          (push_job),
        .release_byte (release_byte),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    brb_job_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .not_full  (queue_ready),
        .pop       (job_pop),
        .head_job  (head_job),
        .not_empty (queue_has_job)
    );

    // The byte store: written by the front part, read by the back part.
    brb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (queue_has_job),
        .job           (head_job),
        .job_pop       (job_pop),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .release_byte  (release_byte),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

`default_nettype wire
